// File: hdl/spic_pkg.sv
// Shared types, widths, register indexes and duty helpers for the speed PI controller.
`default_nettype none

package spic_pkg;

    // field and datapath widths
    localparam int REV_W      = 10;
    localparam int GAIN_W     = 20;
    localparam int TARGET_W   = 24;
    localparam int DUTY_W     = 17;
    localparam int WIN_W      = 7;
    localparam int SPEED_W    = 30;
    localparam int SUM_W      = 36;
    localparam int DVD_W      = 37;
    localparam int ERR_W      = 32;
    localparam int AVG_OUT_W  = 31;
    localparam int PROD_W     = ERR_W + GAIN_W;
    localparam int SHIFT_W    = PROD_W - 16;
    localparam int ACC_W      = 38;
    localparam int WARM_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 17'd65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_WINDOW   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_DUTY  = 3'd7;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // limit a duty register to full scale
    function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] v);
        logic [DUTY_W-1:0] r;
        r = (v > DUTY_FULL) ? DUTY_FULL : v;
        return r;
    endfunction

    // upper clamp first, then lower clamp
    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [ACC_W-1:0] v,
                                                     input logic [DUTY_W-1:0] hi,
                                                     input logic [DUTY_W-1:0] lo);
        logic signed [ACC_W-1:0] hi_s;
        logic signed [ACC_W-1:0] lo_s;
        logic [DUTY_W-1:0]       r;
        hi_s = $signed({{(ACC_W-DUTY_W){1'b0}}, hi});
        lo_s = $signed({{(ACC_W-DUTY_W){1'b0}}, lo});
        if (v > hi_s)
            r = hi;
        else if (v < lo_s)
            r = lo;
        else
            r = v[DUTY_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/spic_mul.sv
// Serial shift-add multiplier: signed multiplicand, unsigned multiplier, one bit per cycle.
`default_nettype none

module spic_mul #(
    parameter int AW = 32,
    parameter int BW = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [AW-1:0]     a,
    input  logic        [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  product,
    output spic_pkg::unit_stat_t     stat
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [BW-1:0] mplier_reg, mplier_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;

    // load operands, then add one shifted partial product per cycle
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = PW'(a);
            mplier_next = b;
            cnt_next    = CW'(BW);
        end
        else if (cnt_reg != '0)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            done_next   = (cnt_reg == CW'(1));
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign product   = $signed(acc_reg);
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// File: hdl/spic_div.sv
// Serial restoring divider by the averaging window, one quotient bit per cycle.
`default_nettype none

module spic_div #(
    parameter int DW = 37
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DW-1:0]                dividend,
    input  logic [spic_pkg::WIN_W-1:0]   divisor,
    output logic [DW-1:0]                quotient,
    output spic_pkg::unit_stat_t         stat
);

    localparam int VW = spic_pkg::WIN_W;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dvd_reg, dvd_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    // bring down one dividend bit, subtract where the divisor fits
    always_comb
    begin
        trial       = {rem_reg, dvd_reg[DW-1]};
        diff        = trial - {1'b0, dsr_reg};
        fits        = (trial >= {1'b0, dsr_reg});
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        dsr_next    = dsr_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CW'(DW);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[VW-1:0] : trial[VW-1:0];
            dvd_next  = {dvd_reg[DW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = dvd_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// File: hdl/speed_pi_controller_with_averaging.sv
// Top level: tick sequencer, averaging state, PI law and output register.
// Usage:
//   Input channel (in_valid / in_stall, rev_count) takes one control tick word:
//   the hall edges counted since the last tick. A tick whose speed is zero
//   (no edges, or a zero speed scale) is taken and dropped with no result.
//   Output channel (out_valid / out_stall) gives one word per active tick:
//   duty_cycle, avg_speed, speed_error and in_warmup.
//   Configuration: write cfg_data to register cfg_index while cfg_we is high;
//   write only while no tick is in flight.
// Datapath:
//   The speed product runs on a serial multiplier, the window division on
//   serial dividers, and the two gain products on serial multipliers. A
//   tick's result shows as the sequencer returns to idle, so the next tick
//   may be taken while that result is shown. A fill tick skips the
//   division.
// Reset and stall:
//   Reset restores the register defaults, clears the average and the integral
//   and restarts the fill and warm-up counts. One result register holds a
//   finished word while out_stall is high; the next tick may be taken and
//   worked meanwhile, and waits at the end until the register is free.
`default_nettype none

module speed_pi_controller_with_averaging #(
    parameter int WARMUP_LIMIT = 25,
    parameter int MAX_WINDOW   = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [spic_pkg::REV_W-1:0]           rev_count,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [spic_pkg::DUTY_W-1:0]          duty_cycle,
    output logic [spic_pkg::AVG_OUT_W-1:0]       avg_speed,
    output logic signed [spic_pkg::ERR_W-1:0]    speed_error,
    output logic                                 in_warmup,
    input  logic                                 cfg_we,
    input  logic [spic_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spic_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DUTY_W  = spic_pkg::DUTY_W;
    localparam int GAIN_W  = spic_pkg::GAIN_W;
    localparam int WIN_W   = spic_pkg::WIN_W;
    localparam int SPEED_W = spic_pkg::SPEED_W;
    localparam int SUM_W   = spic_pkg::SUM_W;
    localparam int DVD_W   = spic_pkg::DVD_W;
    localparam int ERR_W   = spic_pkg::ERR_W;
    localparam int PROD_W  = spic_pkg::PROD_W;
    localparam int SHIFT_W = spic_pkg::SHIFT_W;
    localparam int ACC_W   = spic_pkg::ACC_W;
    localparam int WARM_W  = spic_pkg::WARM_W;
    localparam int SPD_AW  = GAIN_W + 1;
    localparam int SPD_PW  = SPD_AW + spic_pkg::REV_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ERR  = 3'd3;
    localparam logic [2:0] S_PI   = 3'd4;
    localparam logic [2:0] S_DUTY = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // configuration registers
    logic [GAIN_W-1:0]             speed_scale_reg;
    logic [spic_pkg::TARGET_W-1:0] target_speed_reg;
    logic [GAIN_W-1:0]             prop_gain_reg;
    logic [GAIN_W-1:0]             integ_gain_reg;
    logic [DUTY_W-1:0]             duty_high_reg;
    logic [DUTY_W-1:0]             duty_low_reg;
    logic [WIN_W-1:0]              avg_window_reg;
    logic [DUTY_W-1:0]             warmup_duty_reg;

    // sequencer and controller state
    logic [2:0]                state_reg, state_next;
    logic [WIN_W-1:0]          sample_count_reg, sample_count_next;
    logic [SUM_W-1:0]          speed_sum_reg, speed_sum_next;
    logic [SPEED_W-1:0]        speed_avg_reg, speed_avg_next;
    logic [DUTY_W-1:0]         integral_reg, integral_next;
    logic [WARM_W-1:0]         warmup_reg, warmup_next;
    logic                      exp_reg, exp_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [SHIFT_W-1:0] prop_reg, prop_next;
    logic [DUTY_W-1:0]         duty_reg, duty_next;
    logic                      warm_reg, warm_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]         duty_out_reg, duty_out_next;
    logic [spic_pkg::AVG_OUT_W-1:0] avg_out_reg, avg_out_next;
    logic signed [ERR_W-1:0]   err_out_reg, err_out_next;
    logic                      warm_out_reg, warm_out_next;

    // unit hookup
    logic                      spd_start;
    logic signed [SPD_PW-1:0]  spd_prod;
    spic_pkg::unit_stat_t      spd_stat;
    logic                      div_a_start, div_b_start;
    logic [DVD_W-1:0]          div_a_dvd, div_a_quo;
    logic [SPEED_W-1:0]        div_b_dvd, div_b_quo;
    spic_pkg::unit_stat_t      div_a_stat, div_b_stat;
    logic                      gain_start;
    logic signed [ERR_W-1:0]   err_c;
    logic signed [PROD_W-1:0]  prop_prod, integ_prod;
    spic_pkg::unit_stat_t      prop_stat, integ_stat;

    // combinational helpers
    logic                      in_accept;
    logic                      zero_tick;
    logic                      out_free;
    logic [WIN_W-1:0]          win_c;
    logic [SPEED_W-1:0]        speed_c;
    logic [DUTY_W-1:0]         hi_c, lo_c;
    logic signed [ACC_W-1:0]   integ_sum, duty_sum;

    spic_mul #(.AW(SPD_AW), .BW(spic_pkg::REV_W)) u_spd_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (spd_start),
        .a       ($signed({1'b0, speed_scale_reg})),
        .b       (rev_count),
        .product (spd_prod),
        .stat    (spd_stat)
    );

    spic_div #(.DW(DVD_W)) u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_a_start),
        .dividend (div_a_dvd),
        .divisor  (win_c),
        .quotient (div_a_quo),
        .stat     (div_a_stat)
    );

    spic_div #(.DW(SPEED_W)) u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_b_start),
        .dividend (div_b_dvd),
        .divisor  (win_c),
        .quotient (div_b_quo),
        .stat     (div_b_stat)
    );

    spic_mul #(.AW(ERR_W), .BW(GAIN_W)) u_prop_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (gain_start),
        .a       (err_c),
        .b       (prop_gain_reg),
        .product (prop_prod),
        .stat    (prop_stat)
    );

    spic_mul #(.AW(ERR_W), .BW(GAIN_W)) u_integ_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (gain_start),
        .a       (err_c),
        .b       (integ_gain_reg),
        .product (integ_prod),
        .stat    (integ_stat)
    );

    // decode handshakes and limits
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign zero_tick = (rev_count == '0) || (speed_scale_reg == '0);
    assign out_free  = !out_valid_reg || !out_stall;
    assign speed_c   = spd_prod[SPEED_W-1:0];
    assign hi_c      = spic_pkg::sat_duty(duty_high_reg);
    assign lo_c      = spic_pkg::sat_duty(duty_low_reg);
    assign err_c     = $signed({{(ERR_W-spic_pkg::TARGET_W){1'b0}}, target_speed_reg})
                     - $signed({{(ERR_W-SPEED_W){1'b0}}, speed_avg_reg});
    assign integ_sum = ACC_W'($signed(integ_prod[PROD_W-1:16]))
                     + $signed({{(ACC_W-DUTY_W){1'b0}}, integral_reg});
    assign duty_sum  = ACC_W'(prop_reg)
                     + $signed({{(ACC_W-DUTY_W){1'b0}}, integral_reg});

    always_comb
    begin
        if (avg_window_reg == '0)
            win_c = WIN_W'(1);
        else if (avg_window_reg > WIN_W'(MAX_WINDOW))
            win_c = WIN_W'(MAX_WINDOW);
        else
            win_c = avg_window_reg;
    end

    // sequence one tick through the serial units
    always_comb
    begin
        state_next        = state_reg;
        sample_count_next = sample_count_reg;
        speed_sum_next    = speed_sum_reg;
        speed_avg_next    = speed_avg_reg;
        integral_next     = integral_reg;
        warmup_next       = warmup_reg;
        exp_next          = exp_reg;
        err_next          = err_reg;
        prop_next         = prop_reg;
        duty_next         = duty_reg;
        warm_next         = warm_reg;
        out_valid_next    = out_valid_reg && out_stall;
        duty_out_next     = duty_out_reg;
        avg_out_next      = avg_out_reg;
        err_out_next      = err_out_reg;
        warm_out_next     = warm_out_reg;
        spd_start         = 1'b0;
        div_a_start       = 1'b0;
        div_b_start       = 1'b0;
        div_a_dvd         = DVD_W'(speed_c);
        div_b_dvd         = speed_avg_reg;
        gain_start        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // drop a zero-speed tick
                if (in_accept && !zero_tick)
                begin
                    spd_start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (spd_stat.done)
                begin
                    if (sample_count_reg < win_c)
                    begin
                        speed_sum_next    = speed_sum_reg + SUM_W'(speed_c);
                        speed_avg_next    = speed_c;
                        sample_count_next = sample_count_reg + 1'b1;
                        state_next        = S_ERR;
                    end
                    else if (sample_count_reg == win_c)
                    begin
                        div_a_dvd         = DVD_W'(speed_sum_reg) + DVD_W'(speed_c);
                        div_a_start       = 1'b1;
                        exp_next          = 1'b0;
                        sample_count_next = sample_count_reg + 1'b1;
                        state_next        = S_DIV;
                    end
                    else
                    begin
                        div_a_start = 1'b1;
                        div_b_start = 1'b1;
                        exp_next    = 1'b1;
                        state_next  = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (!div_a_stat.busy && !div_b_stat.busy)
                begin
                    if (exp_reg)
                        speed_avg_next = SPEED_W'(({1'b0, speed_avg_reg}
                                                  + {1'b0, div_a_quo[SPEED_W-1:0]})
                                                  - {1'b0, div_b_quo});
                    else
                        speed_avg_next = div_a_quo[SPEED_W-1:0];
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                err_next   = err_c;
                gain_start = 1'b1;
                state_next = S_PI;
            end
            S_PI:
            begin
                // both gain products finish together
                if (prop_stat.done)
                begin
                    integral_next = spic_pkg::clamp_duty(integ_sum, hi_c, lo_c);
                    prop_next     = prop_prod[PROD_W-1:16];
                    state_next    = S_DUTY;
                end
            end
            S_DUTY:
            begin
                duty_next = spic_pkg::clamp_duty(duty_sum, hi_c, lo_c);
                warm_next = 1'b0;
                if (warmup_reg < WARM_W'(WARMUP_LIMIT))
                begin
                    duty_next   = spic_pkg::sat_duty(warmup_duty_reg);
                    warmup_next = warmup_reg + 1'b1;
                    warm_next   = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the result register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    duty_out_next  = duty_reg;
                    avg_out_next   = {1'b0, speed_avg_reg};
                    err_out_next   = err_reg;
                    warm_out_next  = warm_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_reg  <= GAIN_W'(74348);
            target_speed_reg <= spic_pkg::TARGET_W'(98304);
            prop_gain_reg    <= GAIN_W'(13107);
            integ_gain_reg   <= GAIN_W'(655);
            duty_high_reg    <= DUTY_W'(19661);
            duty_low_reg     <= '0;
            avg_window_reg   <= WIN_W'(10);
            warmup_duty_reg  <= DUTY_W'(4588);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spic_pkg::REG_SPEED_SCALE:  speed_scale_reg  <= cfg_data[GAIN_W-1:0];
                spic_pkg::REG_TARGET_SPEED: target_speed_reg <= cfg_data;
                spic_pkg::REG_PROP_GAIN:    prop_gain_reg    <= cfg_data[GAIN_W-1:0];
                spic_pkg::REG_INTEG_GAIN:   integ_gain_reg   <= cfg_data[GAIN_W-1:0];
                spic_pkg::REG_DUTY_HIGH:    duty_high_reg    <= cfg_data[DUTY_W-1:0];
                spic_pkg::REG_DUTY_LOW:     duty_low_reg     <= cfg_data[DUTY_W-1:0];
                spic_pkg::REG_AVG_WINDOW:   avg_window_reg   <= cfg_data[WIN_W-1:0];
                spic_pkg::REG_WARMUP_DUTY:  warmup_duty_reg  <= cfg_data[DUTY_W-1:0];
                default:                    avg_window_reg   <= avg_window_reg;
            endcase
        end
    end

    // control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sample_count_reg <= WIN_W'(1);
            speed_sum_reg    <= '0;
            speed_avg_reg    <= '0;
            integral_reg     <= '0;
            warmup_reg       <= WARM_W'(1);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sample_count_reg <= sample_count_next;
            speed_sum_reg    <= speed_sum_next;
            speed_avg_reg    <= speed_avg_next;
            integral_reg     <= integral_next;
            warmup_reg       <= warmup_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // per-tick payload
    always_ff @(posedge clk)
    begin
        exp_reg      <= exp_next;
        err_reg      <= err_next;
        prop_reg     <= prop_next;
        duty_reg     <= duty_next;
        warm_reg     <= warm_next;
        duty_out_reg <= duty_out_next;
        avg_out_reg  <= avg_out_next;
        err_out_reg  <= err_out_next;
        warm_out_reg <= warm_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign duty_cycle  = duty_out_reg;
    assign avg_speed   = avg_out_reg;
    assign speed_error = err_out_reg;
    assign in_warmup   = warm_out_reg;

endmodule

`default_nettype wire

// File: tb/tb_speed_pi_controller_with_averaging.sv
`timescale 1ns / 100ps
// Testbench for the speed PI controller: random-paced tick words checked against a local model.
module tb_speed_pi_controller_with_averaging;

    localparam int REV_W      = spic_pkg::REV_W;
    localparam int GAIN_W     = spic_pkg::GAIN_W;
    localparam int TARGET_W   = spic_pkg::TARGET_W;
    localparam int DUTY_W     = spic_pkg::DUTY_W;
    localparam int WIN_W      = spic_pkg::WIN_W;
    localparam int ERR_W      = spic_pkg::ERR_W;
    localparam int AVG_OUT_W  = spic_pkg::AVG_OUT_W;
    localparam int WARM_W     = spic_pkg::WARM_W;
    localparam int CFG_IDX_W  = spic_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = spic_pkg::CFG_DATA_W;

    localparam int WARMUP_LIMIT    = 25;
    localparam int MAX_WINDOW      = 64;
    localparam int FULL_SCALE      = 65536;
    localparam int SCALE_DEFAULT   = 74348;
    localparam int WARMUP_DEFAULT  = 4588;
    localparam int DRAIN_CYCLES    = 150;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_PHASES   = 11;
    localparam int PHASE_TICKS     = 120;

    // one result word as the block should give it
    typedef struct {
        logic [DUTY_W-1:0]       duty;
        logic [AVG_OUT_W-1:0]    avg;
        logic signed [ERR_W-1:0] err;
        logic                    warm;
    } pi_word_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [REV_W-1:0]        rev_count;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [DUTY_W-1:0]       duty_cycle;
    logic [AVG_OUT_W-1:0]    avg_speed;
    logic signed [ERR_W-1:0] speed_error;
    logic                    in_warmup;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // local copy of the configuration registers
    logic [GAIN_W-1:0]   scale_reg  = 20'd74348;
    logic [TARGET_W-1:0] target_reg = 24'd98304;
    logic [GAIN_W-1:0]   kp_reg     = 20'd13107;
    logic [GAIN_W-1:0]   ki_reg     = 20'd655;
    logic [DUTY_W-1:0]   high_reg   = 17'd19661;
    logic [DUTY_W-1:0]   low_reg    = 17'd0;
    logic [WIN_W-1:0]    window_reg = 7'd10;
    logic [DUTY_W-1:0]   warm_reg   = 17'd4588;

    // local copy of the controller state
    logic [WIN_W-1:0]  fill_count   = 7'd1;
    longint            speed_sum    = 0;
    longint            speed_mean   = 0;
    longint            integ_acc    = 0;
    logic [WARM_W-1:0] warm_count   = 5'd1;

    pi_word_t pending_words[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       rx_wait        = 0;
    bit       hold_off_req   = 1'b0;
    bit       tx_idle_on     = 1'b1;
    bit       rx_idle_on     = 1'b1;

    speed_pi_controller_with_averaging #(
        .WARMUP_LIMIT (WARMUP_LIMIT),
        .MAX_WINDOW   (MAX_WINDOW)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rev_count   (rev_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duty_cycle  (duty_cycle),
        .avg_speed   (avg_speed),
        .speed_error (speed_error),
        .in_warmup   (in_warmup),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // duty registers above full scale saturate when used
    function automatic longint limit_to_full(input logic [DUTY_W-1:0] v);
        return (v > FULL_SCALE) ? longint'(FULL_SCALE) : longint'(v);
    endfunction

    // upper bound wins over lower bound
    function automatic longint clamp_to_band(input longint v, input longint hi, input longint lo);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // advance the local state by one tick; returns 0 when the tick has no speed
    function automatic bit predict_duty_word(input logic [REV_W-1:0] rev, output pi_word_t w);
        longint spd;
        longint win;
        longint err;
        longint hi;
        longint lo;
        longint duty;
        bit     warm;
        spd = longint'(rev) * longint'(scale_reg);
        if (spd == 0)
            return 0;
        win = longint'(window_reg);
        if (win < 1)
            win = 1;
        if (win > MAX_WINDOW)
            win = MAX_WINDOW;

        // latest speed while filling, plain mean when the fill closes, then truncating exponential update
        if (longint'(fill_count) < win)
        begin
            speed_sum  += spd;
            speed_mean  = spd;
            fill_count++;
        end
        else if (longint'(fill_count) == win)
        begin
            speed_mean = (speed_sum + spd) / win;
            fill_count++;
        end
        else
            speed_mean = speed_mean + spd / win - speed_mean / win;

        // PI law with the integral and the duty held inside the limits
        err       = longint'(target_reg) - speed_mean;
        hi        = limit_to_full(high_reg);
        lo        = limit_to_full(low_reg);
        integ_acc = integ_acc + ((longint'(ki_reg) * err) >>> 16);
        integ_acc = clamp_to_band(integ_acc, hi, lo);
        duty      = ((longint'(kp_reg) * err) >>> 16) + integ_acc;
        duty      = clamp_to_band(duty, hi, lo);

        // warm-up duty overrides the PI output
        warm = 1'b0;
        if (warm_count < WARMUP_LIMIT)
        begin
            duty = limit_to_full(warm_reg);
            warm_count++;
            warm = 1'b1;
        end

        w.duty = duty[DUTY_W-1:0];
        w.avg  = speed_mean[AVG_OUT_W-1:0];
        w.err  = err[ERR_W-1:0];
        w.warm = warm;
        return 1;
    endfunction

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // check each result word, predict each accepted tick word
    always @(posedge clk)
    begin : score_words
        pi_word_t want;
        pi_word_t next_word;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t: result word: expected none, actual duty %0d avg %0d",
                             $time, duty_cycle, avg_speed);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    compare_field("duty_cycle", 64'(want.duty), 64'(duty_cycle));
                    compare_field("avg_speed", 64'(want.avg), 64'(avg_speed));
                    compare_field("speed_error", 64'(want.err), 64'(speed_error));
                    compare_field("in_warmup", 64'(want.warm), 64'(in_warmup));
                end
                rx_wait = rx_idle_on ? $urandom_range(0, 11) : 0;
            end
            if (in_valid && !in_stall)
            begin
                if (predict_duty_word(rev_count, next_word))
                    pending_words.push_back(next_word);
            end
        end
    end

    // drive the receiver stall, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_off_req)
        begin
            rx_wait      = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        out_stall <= (rx_wait != 0);
        if (rx_wait != 0)
            rx_wait--;
    end

    // offer one tick word after a random gap and hold it until taken
    task automatic send_tick(input logic [REV_W-1:0] rev);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        rev_count <= rev;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop valid and wait until every predicted word has come back
    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // let a dropped tick still in flight finish before touching registers
    task automatic settle_block();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            spic_pkg::REG_SPEED_SCALE:  scale_reg  = value[GAIN_W-1:0];
            spic_pkg::REG_TARGET_SPEED: target_reg = value[TARGET_W-1:0];
            spic_pkg::REG_PROP_GAIN:    kp_reg     = value[GAIN_W-1:0];
            spic_pkg::REG_INTEG_GAIN:   ki_reg     = value[GAIN_W-1:0];
            spic_pkg::REG_DUTY_HIGH:    high_reg   = value[DUTY_W-1:0];
            spic_pkg::REG_DUTY_LOW:     low_reg    = value[DUTY_W-1:0];
            spic_pkg::REG_AVG_WINDOW:   window_reg = value[WIN_W-1:0];
            spic_pkg::REG_WARMUP_DUTY:  warm_reg   = value[DUTY_W-1:0];
            default:                    ;
        endcase
    endtask

    task automatic end_config();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // register value biased toward the ends of its range
    function automatic logic [CFG_DATA_W-1:0] pick_value(input int unsigned lo_v,
                                                         input int unsigned hi_v);
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = CFG_DATA_W'(lo_v);
            1:       v = CFG_DATA_W'(hi_v);
            2:       v = CFG_DATA_W'($urandom_range(lo_v + (hi_v - lo_v) / 64, lo_v));
            default: v = CFG_DATA_W'($urandom_range(hi_v, lo_v));
        endcase
        return v;
    endfunction

    // reset values: fill the default window and move into the exponential update
    task automatic test_reset_defaults();
        logic [REV_W-1:0] revs[12];
        revs = '{10'd1023, 10'd1, 10'd0, 10'd2, 10'd700, 10'd512,
                 10'd1, 10'd300, 10'd55, 10'd1023, 10'd9, 10'd400};
        foreach (revs[i])
            send_tick(revs[i]);
    endtask

    // zero speed scale: ticks are taken but give no word
    task automatic test_zero_speed_scale();
        settle_block();
        write_reg(spic_pkg::REG_SPEED_SCALE, '0);
        end_config();
        send_tick(10'd1023);
        send_tick(10'd1);
        settle_block();
        write_reg(spic_pkg::REG_SPEED_SCALE, CFG_DATA_W'(SCALE_DEFAULT));
        end_config();
    endtask

    // window of zero acts as one, window above the maximum acts as the maximum
    task automatic test_window_extremes();
        settle_block();
        write_reg(spic_pkg::REG_AVG_WINDOW, 24'd0);
        end_config();
        send_tick(10'd1023);
        send_tick(10'd3);
        settle_block();
        write_reg(spic_pkg::REG_AVG_WINDOW, 24'd127);
        end_config();
        send_tick(10'd600);
        send_tick(10'd1023);
    endtask

    // duty registers above full scale, lower limit above upper limit, end of warm-up
    task automatic test_duty_limits();
        settle_block();
        write_reg(spic_pkg::REG_DUTY_HIGH, 24'h01FFFF);
        write_reg(spic_pkg::REG_WARMUP_DUTY, 24'h01FFFF);
        end_config();
        send_tick(10'd1023);
        send_tick(10'd40);
        send_tick(10'd1);
        settle_block();
        write_reg(spic_pkg::REG_DUTY_HIGH, 24'd1000);
        write_reg(spic_pkg::REG_DUTY_LOW, 24'd5000);
        write_reg(spic_pkg::REG_WARMUP_DUTY, CFG_DATA_W'(WARMUP_DEFAULT));
        write_reg(spic_pkg::REG_AVG_WINDOW, CFG_DATA_W'(MAX_WINDOW));
        write_reg(spic_pkg::REG_TARGET_SPEED, 24'hFFFFFF);
        end_config();
        for (int i = 0; i < 8; i++)
            send_tick(10'd1 << i);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_long_hold();
        hold_off_req = 1'b1;
        tx_idle_on   = 1'b0;
        repeat (8) send_tick(REV_W'($urandom_range(1, 1023)));
        tx_idle_on   = 1'b1;
    endtask

    // sender pauses until every word is back, then goes on
    task automatic test_sender_pause();
        repeat (5) send_tick(REV_W'($urandom_range(1, 1023)));
        wait_results();
        repeat (5) send_tick(REV_W'($urandom_range(1, 1023)));
    endtask

    // random settings, random pace, random edge counts
    task automatic test_random_phases();
        int               active;
        logic [REV_W-1:0] rev;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle_block();
            write_reg(spic_pkg::REG_SPEED_SCALE, pick_value(32'd1, 32'h000F_FFFF));
            write_reg(spic_pkg::REG_TARGET_SPEED, pick_value(32'd0, 32'h00FF_FFFF));
            write_reg(spic_pkg::REG_PROP_GAIN, pick_value(32'd0, 32'h000F_FFFF));
            write_reg(spic_pkg::REG_INTEG_GAIN, pick_value(32'd0, 32'h000F_FFFF));
            write_reg(spic_pkg::REG_DUTY_HIGH, pick_value(32'd0, 32'h0001_FFFF));
            write_reg(spic_pkg::REG_DUTY_LOW, pick_value(32'd0, 32'h0001_FFFF));
            write_reg(spic_pkg::REG_AVG_WINDOW, pick_value(32'd0, 32'h0000_007F));
            write_reg(spic_pkg::REG_WARMUP_DUTY, pick_value(32'd0, 32'h0001_FFFF));
            end_config();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            active = 0;
            while (active < PHASE_TICKS)
            begin
                case ($urandom_range(0, 15))
                    0:       rev = '0;
                    1:       rev = '1;
                    2:       rev = REV_W'($urandom_range(1, 8));
                    default: rev = REV_W'($urandom_range(0, 1023));
                endcase
                if (rev != 0)
                    active++;
                send_tick(rev);
                if ($urandom_range(0, 199) == 0)
                    wait_results();
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rev_count = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_speed_scale();
        test_window_extremes();
        test_duty_limits();
        test_long_hold();
        test_sender_pause();
        test_random_phases();

        // drain the last words, then watch for strays
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
